// ----- src/gphs_pkg.sv -----
// Shared types, constants and the CDF lookup table for the histogram smoother.
package gphs_pkg;

  localparam int CDF_ENTRIES = 215;
  localparam int TAB_LIMIT   = CDF_ENTRIES - 3;
  localparam int TAB_IDX_W   = 8;

  localparam int PEAK_W      = 32;
  localparam int RADIUS_W    = 24;
  localparam int BINIDX_W    = 8;
  localparam int BIN_W       = 40;
  localparam int COUNT_W     = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 26;

  localparam int CENTRE_W    = 18;
  localparam int XP_W        = 43;
  localparam int DIST_W      = 44;
  localparam int CDF_W       = 33;
  localparam int AREA_W      = 41;

  localparam int OPA_W       = 37;
  localparam int OPB_W       = 34;
  localparam int PROD_W      = OPA_W + OPB_W;
  localparam int ACC_W       = 40;

  localparam logic [BIN_W-1:0] BIN_MAX = '1;
  localparam logic [CDF_W-1:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [OPB_W-1:0] RECIP6  = 34'd2863311531;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_WIDTH       = 3'd0,
    REG_INV_BIN_WIDTH   = 3'd1,
    REG_SMOOTHING_WIDTH = 3'd2,
    REG_INV_SIGMA_SQRT2 = 3'd3,
    REG_BINS_IN_USE     = 3'd4,
    REG_MIN_AREA        = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    CS_IDLE, CS_ZM, CS_Z, CS_TAB, CS_A, CS_AM, CS_P1, CS_P1M,
    CS_P2, CS_P2M, CS_P3, CS_DM, CS_DIV, CS_OUT
  } cdf_state_t;

  typedef enum logic [3:0] {
    TS_CLEAR, TS_IDLE, TS_RDV, TS_CM, TS_C, TS_X0M, TS_X0, TS_CSTART,
    TS_CDF, TS_AM, TS_AREA, TS_WR, TS_RSTEP, TS_LSTART, TS_LSTEP, TS_DONE
  } top_state_t;

  typedef enum logic [1:0] {
    PH_C0, PH_SINGLE, PH_RIGHT, PH_LEFT
  } walk_phase_t;

  typedef logic [33:0] cdf_dec_t [CDF_ENTRIES];
  typedef logic [31:0] cdf_tab_t [CDF_ENTRIES];

  // 0.5*(1+erf(x)) in ten decimal places, x from -0.02 in steps of 0.02
  localparam cdf_dec_t CDF_DEC = '{
    34'd4887177127,
    34'd5000000000, 34'd5112822873, 34'd5225555531, 34'd5338107972, 34'd5450390629,
    34'd5562314580, 34'd5673791759, 34'd5784735165, 34'd5895059066, 34'd6004679195,
    34'd6113512946, 34'd6221479558, 34'd6328500295, 34'd6434498616, 34'd6539400340,
    34'd6643133797, 34'd6745629974, 34'd6846822647, 34'd6946648506, 34'd7045047267,
    34'd7141961775, 34'd7237338092, 34'd7331125576, 34'd7423276950, 34'd7513748353,
    34'd7602499389, 34'd7689493152, 34'd7774696252, 34'd7858078819, 34'd7939614502,
    34'd8019280454, 34'd8097057309, 34'd8172929146, 34'd8246883440, 34'd8318911014,
    34'd8389005969, 34'd8457165616, 34'd8523390389, 34'd8587683764, 34'd8650052156,
    34'd8710504824, 34'd8769053754, 34'd8825713557, 34'd8880501342, 34'd8933436596,
    34'd8984541062, 34'd9033838608, 34'd9081355095, 34'd9127118248, 34'd9171157522,
    34'd9213503965, 34'd9254190089, 34'd9293249733, 34'd9330717933, 34'd9366630792,
    34'd9401025348, 34'd9433939451, 34'd9465411638, 34'd9495481014, 34'd9524187135,
    34'd9551569891, 34'd9577669405, 34'd9602525921, 34'd9626179709, 34'd9648670965,
    34'd9670039725, 34'd9690325775, 34'd9709568576, 34'd9727807183, 34'd9745080176,
    34'd9761425599, 34'd9776880893, 34'd9791482848, 34'd9805267548, 34'd9818270327,
    34'd9830525732, 34'd9842067485, 34'd9852928449, 34'd9863140610, 34'd9872735047,
    34'd9881741917, 34'd9890190442, 34'd9898108898, 34'd9905524607, 34'd9912463935,
    34'd9918952293, 34'd9925014137, 34'd9930672975, 34'd9935951376, 34'd9940870980,
    34'd9945452508, 34'd9949715782, 34'd9953679738, 34'd9957362442, 34'd9960781114,
    34'd9963952146, 34'd9966891125, 34'd9969612854, 34'd9972131377, 34'd9974460002,
    34'd9976611325, 34'd9978597257, 34'd9980429048, 34'd9982117309, 34'd9983672043,
    34'd9985102667, 34'd9986418034, 34'd9987626463, 34'd9988735761, 34'd9989753245,
    34'd9990685769, 34'd9991539742, 34'd9992321156, 34'd9993035606, 34'd9993688306,
    34'd9994284117, 34'd9994827563, 34'd9995322849, 34'd9995773883, 34'd9996184290,
    34'd9996557431, 34'd9996896417, 34'd9997204131, 34'd9997483232, 34'd9997736179,
    34'd9997965240, 34'd9998172504, 34'd9998359896, 34'd9998529185, 34'd9998681998,
    34'd9998819828, 34'd9998944045, 34'd9999055903, 34'd9999156553, 34'd9999247044,
    34'd9999328336, 34'd9999401307, 34'd9999466756, 34'd9999525412, 34'd9999577937,
    34'd9999624934, 34'd9999666952, 34'd9999704488, 34'd9999737994, 34'd9999767878,
    34'd9999794511, 34'd9999818226, 34'd9999839328, 34'd9999858088, 34'd9999874754,
    34'd9999889548, 34'd9999902668, 34'd9999914296, 34'd9999924592, 34'd9999933702,
    34'd9999941757, 34'd9999948872, 34'd9999955152, 34'd9999960691, 34'd9999965573,
    34'd9999969871, 34'd9999973653, 34'd9999976978, 34'd9999979899, 34'd9999982463,
    34'd9999984711, 34'd9999986682, 34'd9999988407, 34'd9999989917, 34'd9999991237,
    34'd9999992390, 34'd9999993396, 34'd9999994274, 34'd9999995039, 34'd9999995705,
    34'd9999996285, 34'd9999996788, 34'd9999997226, 34'd9999997606, 34'd9999997935,
    34'd9999998221, 34'd9999998468, 34'd9999998682, 34'd9999998867, 34'd9999999026,
    34'd9999999164, 34'd9999999283, 34'd9999999386, 34'd9999999474, 34'd9999999550,
    34'd9999999615, 34'd9999999671, 34'd9999999719, 34'd9999999760, 34'd9999999796,
    34'd9999999826, 34'd9999999852, 34'd9999999874, 34'd9999999893, 34'd9999999909,
    34'd9999999923, 34'd9999999935, 34'd9999999945, 34'd9999999953, 34'd9999999960,
    34'd9999999966, 34'd9999999972, 34'd9999999976, 34'd9999999980, 34'd9999999983,
    34'd9999999986, 34'd9999999988, 34'd9999999990, 34'd9999999992
  };

  // Convert decimal entries to Q0.32 with rounding; evaluated at elaboration only
  function automatic cdf_tab_t build_cdf_q32();
    cdf_tab_t tab;
    logic [63:0] scaled;
    for (int k = 0; k < CDF_ENTRIES; k++) begin
      scaled = (64'(CDF_DEC[k]) * 64'd4194304 + 64'd4882812) / 64'd9765625;
      tab[k] = scaled[31:0];
    end
    return tab;
  endfunction

  localparam cdf_tab_t CDF_Q32 = build_cdf_q32();

endpackage

// ----- src/gphs_ifs.sv -----
// Valid/ready channel interfaces for item, result and register write transfers.
interface gphs_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] peak;
  logic [23:0] radius;
  logic [7:0]  bin_index;
  modport source (output valid, req_type, peak, radius, bin_index, input ready);
  modport sink   (input valid, req_type, peak, radius, bin_index, output ready);
endinterface

interface gphs_out_if;
  logic        valid;
  logic        ready;
  logic [39:0] bin_value;
  logic [8:0]  bins_updated;
  modport source (output valid, bin_value, bins_updated, input ready);
  modport sink   (input valid, bin_value, bins_updated, output ready);
endinterface

interface gphs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [25:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/gphs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module gphs_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- src/gphs_cdf.sv -----
// Sequenced normal CDF unit: table lookup with symmetry and cubic interpolation.
module gphs_cdf (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [gphs_pkg::DIST_W-1:0] edge_off,
  input  logic [25:0]                       inv_sigma_sqrt2,
  output logic                              done,
  output logic [gphs_pkg::CDF_W-1:0]        cdf_q
);
  import gphs_pkg::*;

  cdf_state_t state_r, state_nxt;

  logic                     neg_r;
  logic [TAB_IDX_W-1:0]     k_r;
  logic [31:0]              t_r, t0_r, t1_r, t2_r, t3_r;
  logic [CDF_W-1:0]         res_r;
  logic signed [OPA_W-1:0]  opa_r, p_r;
  logic signed [OPB_W-1:0]  opb_r;
  logic signed [PROD_W-1:0] prod_r;

  logic                     neg;
  logic [DIST_W-1:0]        mag;
  logic                     mag_big;
  logic [61:0]              z;
  logic                     z_big;
  logic [45:0]              u;
  logic                     k_sat;
  logic [CDF_W-1:0]         sat_val;
  logic signed [ACC_W-1:0]  x0, x1, x2, x3;
  logic signed [ACC_W-1:0]  a_c, e2_c, e3_c, ps;
  logic signed [ACC_W-1:0]  q, r, qf, v;
  logic [CDF_W-1:0]         vc;

  assign neg     = edge_off < 0;
  assign mag     = neg ? DIST_W'(-edge_off) : DIST_W'(edge_off);
  assign mag_big = (inv_sigma_sqrt2 != '0) && (mag[DIST_W-1:36] != '0);
  assign z       = prod_r[61:0];
  assign z_big   = z[61:40] != '0;
  assign u       = 46'(z[39:0]) * 46'd50;
  assign k_sat   = u[45:32] >= 14'(TAB_LIMIT);
  assign sat_val = neg_r ? '0 : ONE_Q32;

  assign x0   = ACC_W'({1'b0, t0_r});
  assign x1   = ACC_W'({1'b0, t1_r});
  assign x2   = ACC_W'({1'b0, t2_r});
  assign x3   = ACC_W'({1'b0, t3_r});
  assign a_c  = -x0 + 3 * x1 - 3 * x2 + x3;
  assign e2_c = 3 * (x0 - 2 * x1 + x2);
  assign e3_c = -2 * x0 - 3 * x1 + 6 * x2 - x3;
  assign ps   = ACC_W'(prod_r >>> 32);

  // floor(p/6): reciprocal estimate, then one step of correction
  assign q  = ACC_W'(prod_r >>> 34);
  assign r  = ACC_W'(p_r) - ((q <<< 2) + (q <<< 1));
  assign qf = (r < 0) ? q - 1 : ((r >= 6) ? q + 1 : q);
  assign v  = x1 + qf;
  assign vc = (v < 0) ? '0 : ((v > $signed(ACC_W'(ONE_Q32))) ? ONE_Q32 : v[CDF_W-1:0]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: if (start) state_nxt = (inv_sigma_sqrt2 != '0 && mag_big) ? CS_OUT : CS_ZM;
      CS_ZM:   state_nxt = CS_Z;
      CS_Z:    state_nxt = (z_big || k_sat) ? CS_OUT : CS_TAB;
      CS_TAB:  state_nxt = CS_A;
      CS_A:    state_nxt = CS_AM;
      CS_AM:   state_nxt = CS_P1;
      CS_P1:   state_nxt = CS_P1M;
      CS_P1M:  state_nxt = CS_P2;
      CS_P2:   state_nxt = CS_P2M;
      CS_P2M:  state_nxt = CS_P3;
      CS_P3:   state_nxt = CS_DM;
      CS_DM:   state_nxt = CS_DIV;
      CS_DIV:  state_nxt = CS_OUT;
      CS_OUT:  state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    done  = state_r == CS_OUT;
    cdf_q = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= opa_r * opb_r;
    case (state_r)
      CS_IDLE: begin
        if (start) begin
          neg_r <= neg;
          opa_r <= OPA_W'({1'b0, mag[35:0]});
          opb_r <= OPB_W'({8'b0, inv_sigma_sqrt2});
          res_r <= neg ? '0 : ONE_Q32;
        end
      end
      CS_Z: begin
        k_r   <= u[32+TAB_IDX_W-1:32];
        t_r   <= u[31:0];
        res_r <= sat_val;
      end
      CS_TAB: begin
        t0_r <= CDF_Q32[k_r];
        t1_r <= CDF_Q32[k_r + TAB_IDX_W'(1)];
        t2_r <= CDF_Q32[k_r + TAB_IDX_W'(2)];
        t3_r <= CDF_Q32[k_r + TAB_IDX_W'(3)];
      end
      CS_A: begin
        opa_r <= OPA_W'(a_c);
        opb_r <= OPB_W'({2'b0, t_r});
      end
      CS_P1: opa_r <= OPA_W'(ps + e2_c);
      CS_P2: opa_r <= OPA_W'(ps + e3_c);
      CS_P3: begin
        p_r   <= OPA_W'(ps);
        opa_r <= OPA_W'(ps);
        opb_r <= RECIP6;
      end
      CS_DIV: res_r <= neg_r ? ONE_Q32 - vc : vc;
      default: ;
    endcase
  end
endmodule

// ----- src/gaussian_peak_histogram_smoother_top.sv -----
// Top level of the Gaussian peak histogram smoother: sequencer, bin memory, ports.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+----------------------------------------
//  in_ch   | in  | valid/ready      | req_type, peak, radius, bin_index
//  out_ch  | out | valid/ready      | bin_value, bins_updated
//  cfg_ch  | in  | valid/ready (=1) | index, data
//
//  A read goes through accept, memory read and result load. A smoothed deposit
//  first finds the centre and its edge CDF; each bin visited takes a CDF start and
//  its wait, area multiply, compare, read-modify-write and step; the walk then
//  turns and the result is loaded. After reset the bin memory is cleared, one bin per
//  cycle; in_ch stays low-ready until done. A stalled out_ch holds the finished
//  result; the next item is still taken while it waits.
module gaussian_peak_histogram_smoother_top #(
  parameter int NUM_BINS = 256
) (
  input logic          clk,
  input logic          rst_n,
  gphs_in_if.sink      in_ch,
  gphs_out_if.source   out_ch,
  gphs_cfg_if.sink     cfg_ch
);
  import gphs_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);

  top_state_t  state_r, state_nxt;
  walk_phase_t ph_r;

  // configuration registers
  logic [23:0]         bin_width_r;
  logic [25:0]         inv_bin_width_r;
  logic [23:0]         smoothing_width_r;
  logic [25:0]         inv_sigma_sqrt2_r;
  logic [8:0]          bins_in_use_r;
  logic [15:0]         min_area_r;

  // per-item working state
  logic [PEAK_W-1:0]   peak_r;
  logic [RADIUS_W-1:0] radius_r;
  logic                rd_ok_r;
  logic [CENTRE_W-1:0] centre_r, i_r, tgt_r;
  logic [XP_W-1:0]     x0_r, xp_r;
  logic [CDF_W-1:0]    c0_r, cp_r, c1_r;
  logic [AREA_W-1:0]   area_r;
  logic [COUNT_W-1:0]  count_r;
  logic [BIN_W-1:0]    res_val_r;
  logic [IDX_W-1:0]    clr_r;

  // shared multiplier
  logic [31:0]         mt_a_r;
  logic [32:0]         mt_b_r;
  logic [64:0]         mt_p_r;

  // result register
  logic                out_valid_r;
  logic [BIN_W-1:0]    out_bin_value_r;
  logic [COUNT_W-1:0]  out_bins_updated_r;

  logic                in_fire, out_fire, cfg_fire, out_load;
  logic                rd_in_range;
  logic [CENTRE_W-1:0] nb, centre_w, tgt_w;
  logic                centre_in, tgt_in;
  logic signed [OPB_W-1:0] diff;
  logic [AREA_W-1:0]   area_w;
  logic                area_low;
  logic [BIN_W+1:0]    sum;
  logic signed [DIST_W-1:0] edge_off;

  logic                cdf_start, cdf_done;
  logic [CDF_W-1:0]    cdf_res;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [BIN_W-1:0]    ram_wdata, ram_rdata;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign out_load = (state_r == TS_DONE) && (!out_valid_r || out_ch.ready);

  // bins in use, capped at the memory depth
  assign nb = ({9'b0, bins_in_use_r} > CENTRE_W'(NUM_BINS)) ? CENTRE_W'(NUM_BINS)
                                                            : CENTRE_W'(bins_in_use_r);
  assign rd_in_range = {24'b0, in_ch.bin_index} < 32'(NUM_BINS);
  assign centre_w    = mt_p_r[32+CENTRE_W-1:32];
  assign centre_in   = centre_w < nb;
  assign tgt_w       = (ph_r == PH_LEFT) ? i_r - CENTRE_W'(1) : i_r;
  assign tgt_in      = tgt_w < nb;
  assign diff        = (ph_r == PH_RIGHT) ? $signed({1'b0, cdf_res}) - $signed({1'b0, cp_r})
                                          : $signed({1'b0, cp_r}) - $signed({1'b0, cdf_res});
  assign area_w      = mt_p_r[64:24];
  assign area_low    = area_w < AREA_W'(min_area_r);
  assign sum         = {2'b0, ram_rdata} + {1'b0, area_r};
  assign edge_off    = $signed({1'b0, xp_r}) - $signed(DIST_W'(radius_r));

  gphs_cdf u_cdf (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (cdf_start),
    .edge_off        (edge_off),
    .inv_sigma_sqrt2 (inv_sigma_sqrt2_r),
    .done            (cdf_done),
    .cdf_q           (cdf_res)
  );

  gphs_ram #(
    .WIDTH (BIN_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      TS_CLEAR:  if (clr_r == IDX_W'(NUM_BINS - 1)) state_nxt = TS_IDLE;
      TS_IDLE:   if (in_fire) state_nxt = in_ch.req_type ? TS_RDV : TS_CM;
      TS_RDV:    state_nxt = TS_DONE;
      TS_CM:     state_nxt = TS_C;
      TS_C: begin
        if (smoothing_width_r != '0) state_nxt = TS_X0M;
        else state_nxt = centre_in ? TS_WR : TS_DONE;
      end
      TS_X0M:    state_nxt = TS_X0;
      TS_X0:     state_nxt = TS_CSTART;
      TS_CSTART: state_nxt = TS_CDF;
      TS_CDF: begin
        if (cdf_done) begin
          if (ph_r == PH_C0) state_nxt = TS_RSTEP;
          else if (diff < 0) state_nxt = (ph_r == PH_RIGHT) ? TS_LSTART : TS_DONE;
          else state_nxt = TS_AM;
        end
      end
      TS_AM:     state_nxt = TS_AREA;
      TS_AREA: begin
        if (area_low) state_nxt = (ph_r == PH_RIGHT) ? TS_LSTART : TS_DONE;
        else state_nxt = tgt_in ? TS_WR : TS_LSTEP;
      end
      TS_WR: begin
        unique case (ph_r)
          PH_RIGHT: state_nxt = TS_RSTEP;
          PH_LEFT:  state_nxt = TS_LSTEP;
          default:  state_nxt = TS_DONE;
        endcase
      end
      TS_RSTEP:  state_nxt = (i_r < nb) ? TS_CSTART : TS_LSTART;
      TS_LSTART: state_nxt = TS_LSTEP;
      TS_LSTEP:  state_nxt = (i_r != '0) ? TS_CSTART : TS_DONE;
      TS_DONE:   if (out_load) state_nxt = TS_IDLE;
      default:   state_nxt = TS_IDLE;
    endcase
  end

  // outputs: handshakes, memory port and CDF start
  always_comb begin
    in_ch.ready  = state_r == TS_IDLE;
    cfg_ch.ready = 1'b1;
    cdf_start    = state_r == TS_CSTART;
    ram_we       = 1'b0;
    ram_waddr    = tgt_r[IDX_W-1:0];
    ram_wdata    = (sum > {2'b0, BIN_MAX}) ? BIN_MAX : sum[BIN_W-1:0];
    ram_re       = 1'b0;
    ram_raddr    = tgt_w[IDX_W-1:0];
    unique case (state_r)
      TS_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      TS_IDLE: begin
        ram_re    = in_fire && in_ch.req_type && rd_in_range;
        ram_raddr = IDX_W'(in_ch.bin_index);
      end
      TS_C: begin
        ram_re    = (smoothing_width_r == '0) && centre_in;
        ram_raddr = centre_w[IDX_W-1:0];
      end
      TS_AREA:  ram_re = !area_low && tgt_in;
      TS_WR:    ram_we = 1'b1;
      default: ;
    endcase
    out_ch.valid        = out_valid_r;
    out_ch.bin_value    = out_bin_value_r;
    out_ch.bins_updated = out_bins_updated_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TS_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == TS_CLEAR) clr_r <= clr_r + IDX_W'(1);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_width_r       <= 24'd65536;
      inv_bin_width_r   <= 26'd65536;
      smoothing_width_r <= '0;
      inv_sigma_sqrt2_r <= '0;
      bins_in_use_r     <= 9'd256;
      min_area_r        <= 16'd17;
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        REG_BIN_WIDTH:       bin_width_r       <= cfg_ch.data[23:0];
        REG_INV_BIN_WIDTH:   inv_bin_width_r   <= cfg_ch.data;
        REG_SMOOTHING_WIDTH: smoothing_width_r <= cfg_ch.data[23:0];
        REG_INV_SIGMA_SQRT2: inv_sigma_sqrt2_r <= cfg_ch.data;
        REG_BINS_IN_USE:     bins_in_use_r     <= cfg_ch.data[8:0];
        REG_MIN_AREA:        min_area_r        <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // result register: load when the slot is free or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_value_r    <= res_val_r;
      out_bins_updated_r <= count_r;
    end
  end

  // datapath of the walk
  always_ff @(posedge clk) begin
    mt_p_r <= mt_a_r * mt_b_r;
    case (state_r)
      TS_IDLE: begin
        if (in_fire) begin
          peak_r    <= in_ch.peak;
          radius_r  <= in_ch.radius;
          rd_ok_r   <= rd_in_range;
          count_r   <= '0;
          res_val_r <= '0;
          mt_a_r    <= 32'(in_ch.radius);
          mt_b_r    <= 33'(inv_bin_width_r);
        end
      end
      TS_RDV: res_val_r <= rd_ok_r ? ram_rdata : '0;
      TS_C: begin
        centre_r <= centre_w;
        tgt_r    <= centre_w;
        area_r   <= {1'b0, peak_r, 8'b0};
        ph_r     <= PH_SINGLE;
        mt_a_r   <= 32'(centre_w);
        mt_b_r   <= 33'(bin_width_r);
      end
      TS_X0: begin
        x0_r <= mt_p_r[XP_W-1:0];
        xp_r <= mt_p_r[XP_W-1:0];
        ph_r <= PH_C0;
      end
      TS_CDF: begin
        if (cdf_done) begin
          if (ph_r == PH_C0) begin
            c0_r <= cdf_res;
            cp_r <= cdf_res;
            i_r  <= centre_r;
          end else begin
            c1_r   <= cdf_res;
            mt_a_r <= peak_r;
            mt_b_r <= diff[32:0];
          end
        end
      end
      TS_AREA: begin
        if (!area_low) begin
          cp_r   <= c1_r;
          area_r <= area_w;
          tgt_r  <= tgt_w;
          if (!tgt_in) i_r <= i_r - CENTRE_W'(1);
        end
      end
      TS_WR: begin
        count_r <= count_r + COUNT_W'(1);
        if (ph_r == PH_RIGHT) i_r <= i_r + CENTRE_W'(1);
        if (ph_r == PH_LEFT)  i_r <= i_r - CENTRE_W'(1);
      end
      TS_RSTEP: begin
        if (i_r < nb) begin
          xp_r <= xp_r + XP_W'(bin_width_r);
          ph_r <= PH_RIGHT;
        end
      end
      TS_LSTART: begin
        i_r  <= centre_r;
        xp_r <= x0_r;
        cp_r <= c0_r;
      end
      TS_LSTEP: begin
        if (i_r != '0) begin
          xp_r <= xp_r - XP_W'(bin_width_r);
          ph_r <= PH_LEFT;
        end
      end
      default: ;
    endcase
  end

  // memory writes only come from the clearing sweep or a bin update
  a_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == TS_CLEAR || state_r == TS_WR))
    else $error("bin memory written outside clear or update");

  // the CDF unit answers only while the walk waits for it
  a_cdf_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cdf_done |-> (state_r == TS_CDF))
    else $error("CDF result arrived while not waiting");

  // CDF value stays within [0, 1]
  a_cdf_range: assert property (@(posedge clk) disable iff (!rst_n)
    cdf_done |-> (cdf_res <= ONE_Q32))
    else $error("CDF value out of range");

  // a deposit never updates more bins than are in use
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == TS_DONE) |-> (CENTRE_W'(count_r) <= nb))
    else $error("bin update count exceeds bins in use");

  // an accepted item always leaves the idle state
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != TS_IDLE))
    else $error("accepted item did not start processing");
endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the Gaussian peak histogram smoother top level.
module tb;
  import gphs_pkg::*;

  localparam int         NBINS      = 256;
  localparam logic       REQ_DEPOSIT = 1'b0;
  localparam logic       REQ_READ    = 1'b1;
  localparam longint     ONE_CDF     = 64'sh1_0000_0000;
  localparam longint     SAT_BIN     = (64'sd1 << 40) - 1;
  localparam int         IDLE_PAUSE  = 40;
  localparam longint     CYCLE_LIMIT = 20_000_000;
  localparam int         MAX_CENTRE  = 600;

  typedef struct packed {
    logic [BIN_W-1:0]   bin_value;
    logic [COUNT_W-1:0] bins_updated;
  } bin_result_t;

  logic clk;
  logic rst_n;

  gphs_in_if  in_if();
  gphs_out_if out_if();
  gphs_cfg_if cfg_if();

  gaussian_peak_histogram_smoother_top #(.NUM_BINS(NBINS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow copy of the block's registers and bin memory
  longint      bw_q, inv_bw_q, sigma_q, inv_sig_q, nb_q, min_area_q;
  longint      hist_shadow [NBINS];
  longint      gauss_tab [CDF_ENTRIES];
  bin_result_t pending_results [$];

  int     fail_count;
  int     n_deposits, n_reads, n_cfg_writes, n_checked;
  longint cycle_count = 0;
  bit     sender_steady;
  int     burst_left;

  // Clock and cycle watchdog
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** gaussian_peak_histogram_smoother_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor: table, CDF interpolation, bin walks
  // ---------------------------------------------------------------------------
  function automatic longint gauss_cdf(longint edge_off);
    bit     neg;
    longint mag, z, u, k, t, t0, t1, t2, t3, p, v;
    neg = edge_off < 0;
    mag = neg ? -edge_off : edge_off;
    z = 0;
    if (inv_sig_q != 0) begin
      if (mag >= (64'sd1 << 36)) return neg ? 0 : ONE_CDF;
      z = mag * inv_sig_q;
      if (z >= (64'sd1 << 40)) return neg ? 0 : ONE_CDF;
    end
    u = z * 50;
    k = u >>> 32;
    if (k >= TAB_LIMIT) return neg ? 0 : ONE_CDF;
    t  = u & 64'hFFFF_FFFF;
    t0 = gauss_tab[k];
    t1 = gauss_tab[k+1];
    t2 = gauss_tab[k+2];
    t3 = gauss_tab[k+3];
    // Horner in sixths; each product floored back to Q0.32
    p = -t0 + 3*t1 - 3*t2 + t3;
    p = ((p * t) >>> 32) + 3*(t0 - 2*t1 + t2);
    p = ((p * t) >>> 32) + (-2*t0 - 3*t1 + 6*t2 - t3);
    p = (p * t) >>> 32;
    v = t1 + ((p >= 0) ? p / 6 : -((-p + 5) / 6));
    if (v < 0) v = 0;
    if (v > ONE_CDF) v = ONE_CDF;
    return neg ? ONE_CDF - v : v;
  endfunction

  function automatic longint centre_of(longint radius);
    return (radius * inv_bw_q) >>> 32;
  endfunction

  function automatic void add_to_bin(longint idx, longint amount);
    longint s;
    s = hist_shadow[idx] + amount;
    hist_shadow[idx] = (s > SAT_BIN) ? SAT_BIN : s;
  endfunction

  // Stop a walk on a negative area or one below the threshold
  function automatic bit area_ok(longint pk, longint hi, longint lo, output longint area);
    logic [63:0] prod;
    area = 0;
    if (hi - lo < 0) return 0;
    prod = 64'(pk) * 64'(hi - lo);
    area = longint'(prod >> 24);
    return area >= min_area_q;
  endfunction

  function automatic bin_result_t predict_item(logic req, logic [31:0] pk_in,
                                               logic [23:0] rad_in, logic [7:0] idx);
    bin_result_t r;
    longint pk, rad, nb, ctr, cnt, area, i, x0, xp, cp, c1;
    pk  = longint'(pk_in);
    rad = longint'(rad_in);
    r   = '0;
    cnt = 0;
    if (req == REQ_READ) begin
      r.bin_value = hist_shadow[idx][BIN_W-1:0];
      return r;
    end
    nb  = (nb_q > NBINS) ? NBINS : nb_q;
    ctr = centre_of(rad);
    if (sigma_q == 0) begin
      if (ctr < nb) begin
        add_to_bin(ctr, pk << 8);
        cnt = 1;
      end
    end else begin
      x0 = ctr * bw_q;
      xp = x0;
      cp = gauss_cdf(x0 - rad);
      for (i = ctr; i < nb; i++) begin
        xp += bw_q;
        c1 = gauss_cdf(xp - rad);
        if (!area_ok(pk, c1, cp, area)) break;
        add_to_bin(i, area);
        cnt++;
        cp = c1;
      end
      xp = x0;
      cp = gauss_cdf(x0 - rad);
      for (i = ctr; i > 0; i--) begin
        xp -= bw_q;
        c1 = gauss_cdf(xp - rad);
        if (!area_ok(pk, cp, c1, area)) break;
        if (i - 1 < nb) begin
          add_to_bin(i - 1, area);
          cnt++;
        end
        cp = c1;
      end
    end
    r.bins_updated = cnt[COUNT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare each transfer with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bin_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result bin_value=%h bins_updated=%0d", $time,
                 out_if.bin_value, out_if.bins_updated);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (out_if.bin_value !== exp_r.bin_value) begin
          $display("%0t: bin_value mismatch expected %h actual %h", $time,
                   exp_r.bin_value, out_if.bin_value);
          fail_count++;
        end
        if (out_if.bins_updated !== exp_r.bins_updated) begin
          $display("%0t: bins_updated mismatch expected %0d actual %0d", $time,
                   exp_r.bins_updated, out_if.bins_updated);
          fail_count++;
        end
      end
    end
  end

  // Receiver back-pressure: switch pattern every so often, including no stall
  initial begin
    int mode, phase_len, stall;
    out_if.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      phase_len = $urandom_range(20, 150);
      repeat (phase_len) begin
        @(negedge clk);
        case (mode)
          0: out_if.ready = 1'b1;
          1: out_if.ready = 1'($urandom_range(0, 1));
          2: out_if.ready = (cycle_count % 7) < 3;
          default: begin
            stall = $urandom_range(0, 9);
            out_if.ready = (stall != 0);
            if (stall == 0) repeat ($urandom_range(1, 40)) @(negedge clk);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Send one item; enters and leaves at a falling edge, valid stays high
  task automatic send_item(logic req, logic [31:0] pk, logic [23:0] rad, logic [7:0] idx);
    int gap;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 12);
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left--;
    end
    in_if.valid     = 1'b1;
    in_if.req_type  = req;
    in_if.peak      = pk;
    in_if.radius    = rad;
    in_if.bin_index = idx;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(predict_item(req, pk, rad, idx));
    if (req == REQ_READ) n_reads++;
    else n_deposits++;
    @(negedge clk);
  endtask

  // Hold until every expected result has arrived, then let the block settle
  task automatic drain;
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (IDLE_PAUSE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, longint value);
    drain();
    cfg_if.valid = 1'b1;
    cfg_if.index = r;
    cfg_if.data  = value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    case (r)
      REG_BIN_WIDTH:       bw_q       = value & 64'hFF_FFFF;
      REG_INV_BIN_WIDTH:   inv_bw_q   = value & 64'h3FF_FFFF;
      REG_SMOOTHING_WIDTH: sigma_q    = value & 64'hFF_FFFF;
      REG_INV_SIGMA_SQRT2: inv_sig_q  = value & 64'h3FF_FFFF;
      REG_BINS_IN_USE:     nb_q       = value & 64'h1FF;
      REG_MIN_AREA:        min_area_q = value & 64'hFFFF;
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Consistent geometry: bin width with its reciprocal, sigma with its factor
  task automatic setup_kernel(longint bw, longint sig_ratio4, longint nb, longint ma);
    longint sig, inv_sig;
    sig = (bw * sig_ratio4) / 4;
    if (sig > 64'hFF_FFFF) sig = 64'hFF_FFFF;
    if (sig < 1) sig = 1;
    inv_sig = longint'(4294967296.0 / (real'(sig) * 1.4142135623730951));
    if (inv_sig > 64'h3FF_FFFF) inv_sig = 64'h3FF_FFFF;
    write_reg(REG_BIN_WIDTH, bw);
    write_reg(REG_INV_BIN_WIDTH, (64'sd1 << 32) / bw);
    write_reg(REG_SMOOTHING_WIDTH, sig);
    write_reg(REG_INV_SIGMA_SQRT2, inv_sig);
    write_reg(REG_BINS_IN_USE, nb);
    write_reg(REG_MIN_AREA, ma);
  endtask

  // Position near a chosen bin, pulled in so walks stay short
  function automatic logic [23:0] radius_near(longint bin);
    longint rad;
    rad = bin * bw_q + $urandom_range(0, (bw_q > 1) ? bw_q - 1 : 0);
    rad = rad & 64'hFF_FFFF;
    while (centre_of(rad) > MAX_CENTRE) rad = rad >> 1;
    return rad[23:0];
  endfunction

  task automatic random_items(int count);
    longint nb_eff;
    logic [31:0] pk;
    nb_eff = (nb_q > NBINS) ? NBINS : nb_q;
    repeat (count) begin
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 3))
          0: pk = $urandom;
          1: pk = $urandom_range(0, 32'h0001_0000);
          2: pk = 32'hFFFF_FFFF - $urandom_range(0, 255);
          default: pk = $urandom_range(32'h1000, 32'h0100_0000);
        endcase
        send_item(REQ_DEPOSIT, pk, radius_near($urandom_range(0, nb_eff + 4)),
                  8'($urandom));
      end else begin
        send_item(REQ_READ, $urandom, 24'($urandom), 8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset state: no smoothing, direct deposit, saturation of a bin
  task automatic test_direct_deposit;
    send_item(REQ_READ, 32'h0, 24'h0, 8'd0);
    send_item(REQ_DEPOSIT, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF);
    send_item(REQ_DEPOSIT, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'h00);
    send_item(REQ_READ, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF);
    send_item(REQ_DEPOSIT, 32'h0, 24'h0, 8'h00);
    send_item(REQ_READ, 32'h0, 24'h0, 8'h00);
  endtask

  // Smoothed deposit with sane geometry, centre in and out of range
  task automatic test_smoothed;
    setup_kernel(65536, 6, 200, 17);
    send_item(REQ_DEPOSIT, 32'h0010_0000, 24'h32_8000, 8'd0);
    send_item(REQ_READ, 32'h0, 24'h0, 8'd50);
    send_item(REQ_DEPOSIT, 32'hFFFF_FFFF, 24'hCB_0000, 8'd0);
    send_item(REQ_READ, 32'h0, 24'h0, 8'd199);
    send_item(REQ_DEPOSIT, 32'h0001_0000, 24'h00_4000, 8'd0);
  endtask

  // Degenerate registers: zero factor, tiny sigma, bins in use of 0 and 511
  task automatic test_register_extremes;
    write_reg(REG_INV_SIGMA_SQRT2, 0);
    send_item(REQ_DEPOSIT, 32'h0100_0000, 24'h05_0000, 8'd0);
    write_reg(REG_MIN_AREA, 65535);
    write_reg(REG_INV_SIGMA_SQRT2, 64'h3FF_FFFF);
    send_item(REQ_DEPOSIT, 32'hFFFF_FFFF, 24'h05_8000, 8'd0);
    write_reg(REG_BINS_IN_USE, 0);
    send_item(REQ_DEPOSIT, 32'hFFFF_FFFF, 24'h05_8000, 8'd0);
    write_reg(REG_BINS_IN_USE, 511);
    write_reg(REG_MIN_AREA, 0);
    write_reg(REG_SMOOTHING_WIDTH, 64'hFF_FFFF);
    write_reg(REG_BIN_WIDTH, 64'hFF_FFFF);
    write_reg(REG_INV_BIN_WIDTH, 1);
    send_item(REQ_DEPOSIT, 32'h8000_0000, 24'hFF_FFFF, 8'd0);
    write_reg(REG_BIN_WIDTH, 1);
    write_reg(REG_INV_BIN_WIDTH, 64'h3FF_FFFF);
    write_reg(REG_MIN_AREA, 17);
    send_item(REQ_DEPOSIT, 32'h0000_0001, 24'h00_0400, 8'd0);
    send_item(REQ_READ, 32'h0, 24'h0, 8'd16);
  endtask

  // Random phases over a range of geometries, some with a steady sender
  task automatic test_random_phases;
    for (int ph = 0; ph < 9; ph++) begin
      sender_steady = (ph % 3 == 2);
      if (ph == 4) begin
        write_reg(REG_SMOOTHING_WIDTH, 0);
        write_reg(REG_BINS_IN_USE, 256);
      end else begin
        setup_kernel($urandom_range(4096, 262144), $urandom_range(1, 10),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511)
                                                 : $urandom_range(1, 256),
                     ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4096));
      end
      random_items(60);
    end
    sender_steady = 1'b0;
  endtask

  initial begin
    fail_count = 0; n_deposits = 0; n_reads = 0; n_cfg_writes = 0; n_checked = 0;
    sender_steady = 1'b0;
    burst_left = 0;
    bw_q = 65536; inv_bw_q = 65536; sigma_q = 0; inv_sig_q = 0;
    nb_q = 256; min_area_q = 17;
    foreach (hist_shadow[i]) hist_shadow[i] = 0;
    // Round the decimal table to Q0.32
    for (int k = 0; k < CDF_ENTRIES; k++)
      gauss_tab[k] = longint'((64'(CDF_DEC[k]) * 64'd4194304 + 64'd4882812) / 64'd9765625);

    in_if.valid = 1'b0; in_if.req_type = REQ_DEPOSIT;
    in_if.peak = '0; in_if.radius = '0; in_if.bin_index = '0;
    cfg_if.valid = 1'b0; cfg_if.index = REG_BIN_WIDTH; cfg_if.data = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_direct_deposit();
    test_smoothed();
    test_register_extremes();
    test_random_phases();

    drain();
    $display("covered %0d deposits, %0d reads, %0d register writes; %0d results checked",
             n_deposits, n_reads, n_cfg_writes, n_checked);
    if (fail_count == 0) begin
      $display("** gaussian_peak_histogram_smoother_top: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** gaussian_peak_histogram_smoother_top: FAILED **");
    end
    $finish;
  end

endmodule
